// ===== hw/rtl/serial_motor_command_unit_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef SERIAL_MOTOR_COMMAND_UNIT_DEFINES_SVH
`define SERIAL_MOTOR_COMMAND_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMCU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smcu check failed");

// Next-cycle implication, checked outside reset.
`define SMCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smcu check failed");

`endif

// ===== hw/rtl/smcu_pkg.sv =====
package smcu_pkg;

    localparam int SUM_W = 15;

    typedef logic [1:0] t_req_type;
    localparam t_req_type REQ_BYTE   = 2'd0;
    localparam t_req_type REQ_TICK   = 2'd1;
    localparam t_req_type REQ_SAMPLE = 2'd2;

    typedef logic [1:0] t_cls;
    localparam t_cls CLS_DUTY = 2'd0;
    localparam t_cls CLS_READ = 2'd1;
    localparam t_cls CLS_SET  = 2'd2;
    localparam t_cls CLS_CLR  = 2'd3;

    localparam logic [5:0] CH_A     = 6'd1;
    localparam logic [5:0] CH_B     = 6'd2;
    localparam logic [5:0] CH_RELAY = 6'd3;
    localparam logic [5:0] CH_LAP   = 6'd5;

    typedef logic t_cfg_index;
    localparam t_cfg_index CFG_PRESS   = 1'b0;
    localparam t_cfg_index CFG_RELEASE = 1'b1;

    localparam logic [7:0] PRESS_TICKS_RST   = 8'd198;
    localparam logic [7:0] RELEASE_TICKS_RST = 8'd50;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_ADC  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic       rx_fault;
        logic       switch_level;
        logic [9:0] adc_sample;
    } t_req;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        adc_start;
        logic [5:0]  adc_channel;
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic        dir_a;
        logic        dir_b;
        logic        relay_state;
        logic        last;
    } t_rsp;

endpackage

// ===== hw/rtl/serial_motor_command_unit.sv =====
// Serial motor command unit. Requests are serial bytes, timer ticks and converter samples;
// each request yields one status response, or two (high byte, then low byte) when it
// completes a lap-count or converter-average reply. A request is taken into an input
// register and decoded from there into a two-deep response register, whose first entry
// drives the response port. Requests with a single response flow at one per clock while
// each response is taken; a request with a reply keeps its low byte in the second entry,
// and no further request is decoded until its high byte has been taken. Configuration is
// always ready.
`include "serial_motor_command_unit_defines.svh"

module serial_motor_command_unit #(
    parameter int ADC_SAMPLES = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  smcu_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output smcu_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import smcu_pkg::*;

    localparam int LEFT_W    = $clog2(ADC_SAMPLES + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(ADC_SAMPLES);
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + ADC_SAMPLES - 1) / ADC_SAMPLES;
    localparam logic [15:0] DIV_MUL_16 = DIV_MUL[15:0];

    logic [7:0]        r_press_ticks;
    logic [7:0]        r_release_ticks;

    logic              r_in_v;
    t_req              r_in;
    logic              r_out_v;
    t_rsp              r_out;
    logic              r_sec_v;
    t_rsp              r_sec;

    t_phase            r_phase,   n_phase;
    logic [5:0]        r_chan,    n_chan;
    logic [7:0]        r_dhigh,   n_dhigh;
    logic [15:0]       r_duty_a,  n_duty_a;
    logic [15:0]       r_duty_b,  n_duty_b;
    logic              r_dir_a,   n_dir_a;
    logic              r_dir_b,   n_dir_b;
    logic              r_relay,   n_relay;
    logic              r_forward, n_forward;
    logic [15:0]       r_laps,    n_laps;
    logic              r_busy,    n_busy;
    logic              r_armed,   n_armed;
    logic [7:0]        r_run,     n_run;
    logic [SUM_W-1:0]  r_sum,     n_sum;
    logic [LEFT_W-1:0] r_left,    n_left;

    logic              fire;
    logic              pop;
    logic              reply;
    logic              start;
    logic [15:0]       value;
    logic [SUM_W+15:0] prod;
    logic [7:0]        run_inc;
    t_cls              cls;
    logic [5:0]        ch;
    t_rsp              item0;
    t_rsp              item1;

    assign pop         = r_out_v && i_rsp_ready;
    assign fire        = r_in_v && !r_sec_v && (!r_out_v || i_rsp_ready);
    assign o_req_ready = !r_in_v || fire;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

    assign cls     = r_in.rx_byte[7:6];
    assign ch      = r_in.rx_byte[5:0];
    assign run_inc = (r_run == 8'hff) ? r_run : r_run + 8'd1;
    assign prod    = n_sum * DIV_MUL_16;

    always_comb begin
        n_phase   = r_phase;
        n_chan    = r_chan;
        n_dhigh   = r_dhigh;
        n_duty_a  = r_duty_a;
        n_duty_b  = r_duty_b;
        n_dir_a   = r_dir_a;
        n_dir_b   = r_dir_b;
        n_relay   = r_relay;
        n_forward = r_forward;
        n_laps    = r_laps;
        n_busy    = r_busy;
        n_armed   = r_armed;
        n_run     = r_run;
        n_sum     = r_sum;
        n_left    = r_left;
        reply     = 1'b0;
        start     = 1'b0;
        value     = '0;
        case (r_in.req_type)
            REQ_BYTE: begin
                if (!r_in.rx_fault) begin
                    unique case (r_phase)
                        PH_HIGH: begin
                            n_dhigh = r_in.rx_byte;
                            n_phase = PH_LOW;
                        end
                        PH_LOW: begin
                            if (r_chan == CH_A) n_duty_a = {r_dhigh, r_in.rx_byte};
                            else if (r_chan == CH_B) n_duty_b = {r_dhigh, r_in.rx_byte};
                            n_phase = PH_IDLE;
                        end
                        PH_ADC: begin
                        end
                        default: begin
                            unique case (cls)
                                CLS_DUTY: begin
                                    n_chan  = ch;
                                    n_phase = PH_HIGH;
                                end
                                CLS_READ: begin
                                    if (ch == CH_LAP) begin
                                        reply = 1'b1;
                                        value = r_laps;
                                    end else begin
                                        n_chan  = ch;
                                        n_sum   = '0;
                                        n_left  = LEFT_W'(ADC_SAMPLES);
                                        n_phase = PH_ADC;
                                        start   = 1'b1;
                                    end
                                end
                                default: begin
                                    if (ch == CH_RELAY) begin
                                        n_relay = (cls == CLS_SET);
                                    end else begin
                                        if (ch == CH_A) n_dir_a = (cls == CLS_SET);
                                        if (ch == CH_B) n_dir_b = (cls == CLS_SET);
                                        n_forward = (cls == CLS_CLR);
                                    end
                                end
                            endcase
                        end
                    endcase
                end
            end
            REQ_TICK: begin
                if (r_busy) begin
                    if (!r_in.switch_level) begin
                        n_run = '0;
                    end else if (run_inc >= r_release_ticks) begin
                        n_busy  = 1'b0;
                        n_run   = '0;
                        n_armed = 1'b1;
                    end else begin
                        n_run = run_inc;
                    end
                end else if (r_in.switch_level) begin
                    n_armed = 1'b1;
                    n_run   = '0;
                end else if (r_armed) begin
                    if (run_inc >= r_press_ticks) begin
                        n_laps  = r_forward ? r_laps + 16'd1 : r_laps - 16'd1;
                        n_busy  = 1'b1;
                        n_armed = 1'b0;
                        n_run   = '0;
                    end else begin
                        n_run = run_inc;
                    end
                end
            end
            REQ_SAMPLE: begin
                if (r_phase == PH_ADC) begin
                    n_sum = SUM_W'(r_sum + SUM_W'(r_in.adc_sample));
                    if (r_left != '0) n_left = r_left - LEFT_W'(1);
                    if (r_left <= LEFT_W'(1)) begin
                        reply   = 1'b1;
                        value   = 16'(prod >> DIV_SHIFT);
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        item0.tx_valid    = reply;
        item0.tx_byte     = reply ? value[15:8] : 8'd0;
        item0.adc_start   = start;
        item0.adc_channel = n_chan;
        item0.duty_a      = n_duty_a;
        item0.duty_b      = n_duty_b;
        item0.dir_a       = n_dir_a;
        item0.dir_b       = n_dir_b;
        item0.relay_state = n_relay;
        item0.last        = !reply;
        item1             = item0;
        item1.tx_byte     = value[7:0];
        item1.adc_start   = 1'b0;
        item1.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks   <= PRESS_TICKS_RST;
            r_release_ticks <= RELEASE_TICKS_RST;
            r_in_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_sec_v   <= 1'b0;
            r_phase   <= PH_IDLE;
            r_chan    <= '0;
            r_dhigh   <= '0;
            r_duty_a  <= '0;
            r_duty_b  <= '0;
            r_dir_a   <= 1'b0;
            r_dir_b   <= 1'b0;
            r_relay   <= 1'b0;
            r_forward <= 1'b1;
            r_laps    <= '0;
            r_busy    <= 1'b0;
            r_armed   <= 1'b0;
            r_run     <= '0;
            r_sum     <= '0;
            r_left    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PRESS:   r_press_ticks   <= i_cfg_data;
                    CFG_RELEASE: r_release_ticks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (o_req_ready) begin
                r_in_v <= i_req_valid;
                r_in   <= i_req;
            end
            if (fire) begin
                r_out_v   <= 1'b1;
                r_out     <= item0;
                r_sec_v   <= reply;
                r_sec     <= item1;
                r_phase   <= n_phase;
                r_chan    <= n_chan;
                r_dhigh   <= n_dhigh;
                r_duty_a  <= n_duty_a;
                r_duty_b  <= n_duty_b;
                r_dir_a   <= n_dir_a;
                r_dir_b   <= n_dir_b;
                r_relay   <= n_relay;
                r_forward <= n_forward;
                r_laps    <= n_laps;
                r_busy    <= n_busy;
                r_armed   <= n_armed;
                r_run     <= n_run;
                r_sum     <= n_sum;
                r_left    <= n_left;
            end else if (pop) begin
                r_out_v <= r_sec_v;
                r_out   <= r_sec;
                r_sec_v <= 1'b0;
            end
        end
    end

    `SMCU_ASSERT_NOW(a_sec_behind_out, i_clk, i_rst_n, r_sec_v, r_out_v)
    `SMCU_ASSERT_NOW(a_sec_after_high, i_clk, i_rst_n, r_sec_v, r_out.tx_valid && !r_out.last)
    `SMCU_ASSERT_NOW(a_high_has_low, i_clk, i_rst_n, r_out_v && !r_out.last, r_sec_v)
    `SMCU_ASSERT_NOW(a_adc_left, i_clk, i_rst_n, r_phase == PH_ADC, r_left != '0)
    `SMCU_ASSERT_NOW(a_busy_disarmed, i_clk, i_rst_n, r_busy, !r_armed)
    `SMCU_ASSERT_NEXT(a_reply_blocks, i_clk, i_rst_n, fire && reply, !fire)

endmodule
